@@ design/lcpc_pkg.sv @@
package lcpc_pkg;

   // number format
   localparam int FRAC_BITS  = 8;
   localparam int RAW_W      = 16;
   localparam int OUT_W      = 14;
   localparam int NUM_LANES  = 4;
   localparam int CAL_W      = 3 * RAW_W;
   localparam int CSR_W      = CAL_W;
   localparam int CSR_IDX_W  = 2;

   // 17 kg in fixed point, and the widths that follow from it
   localparam int MID_KG     = 17;
   localparam int MID_VAL    = MID_KG << FRAC_BITS;
   localparam int QUO_W      = $clog2(MID_VAL);
   localparam int PROD_W     = RAW_W + QUO_W;
   localparam int WGT_W      = QUO_W + 1;
   localparam int OUT_MAX    = (1 << OUT_W) - 1;
   localparam int KG_CEIL    = (2 * MID_VAL > OUT_MAX) ? OUT_MAX : 2 * MID_VAL;

   // one restoring step per quotient bit, behind a front stage and a multiply stage
   localparam int DIV_STAGES = QUO_W;
   localparam int PIPE_DEPTH = DIV_STAGES + 2;

   localparam logic [QUO_W-1:0] MID_Q   = QUO_W'(MID_VAL);
   localparam logic [WGT_W-1:0] MID_WGT = WGT_W'(MID_VAL);
   localparam logic [WGT_W-1:0] TOP_WGT = WGT_W'(2 * MID_VAL);

   // register indexes, also the lane order
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TOP_RIGHT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BOTTOM_RIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TOP_LEFT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BOTTOM_LEFT  = 2'd3;

   localparam int LANE_TOP_RIGHT    = 0;
   localparam int LANE_BOTTOM_RIGHT = 1;
   localparam int LANE_TOP_LEFT     = 2;
   localparam int LANE_BOTTOM_LEFT  = 3;

   typedef struct packed {
      logic [RAW_W-1:0] raw_top_right;
      logic [RAW_W-1:0] raw_bottom_right;
      logic [RAW_W-1:0] raw_top_left;
      logic [RAW_W-1:0] raw_bottom_left;
   } req_data_type;

   typedef struct packed {
      logic [OUT_W-1:0] kg_top_right;
      logic [OUT_W-1:0] kg_bottom_right;
      logic [OUT_W-1:0] kg_top_left;
      logic [OUT_W-1:0] kg_bottom_left;
   } rsp_data_type;

   function automatic logic [OUT_W-1:0] sat_kg(input logic [WGT_W-1:0] w);
      logic [OUT_W-1:0] r;
      if (32'(w) > 32'(OUT_MAX)) begin
         r = OUT_W'(OUT_MAX);
      end else begin
         r = OUT_W'(w);
      end
      return r;
   endfunction

endpackage

@@ design/lcpc_lane.sv @@
module lcpc_lane import lcpc_pkg::*; (
   input  logic                  clock,
   input  logic [PIPE_DEPTH-1:0] stage_en,
   input  logic [RAW_W-1:0]      raw,
   input  logic [CAL_W-1:0]      cal,
   output logic [WGT_W-1:0]      wgt
);

   logic [RAW_W-1:0] p0, p1, p2;
   logic [RAW_W-1:0] diff_in, fdiv_in;
   logic [WGT_W-1:0] fbase_in;

   logic [RAW_W-1:0] diff_ff, fdiv_ff;
   logic [WGT_W-1:0] fbase_ff;

   logic [PROD_W-1:0] prod_in;

   logic [PROD_W-1:0] rem_ff  [DIV_STAGES];
   logic [RAW_W-1:0]  div_ff  [DIV_STAGES];
   logic [WGT_W-1:0]  base_ff [DIV_STAGES+1];
   logic [QUO_W-1:0]  quo_ff  [DIV_STAGES+1];

   assign p0 = cal[RAW_W-1:0];
   assign p1 = cal[2*RAW_W-1:RAW_W];
   assign p2 = cal[3*RAW_W-1:2*RAW_W];

   // segment pick; outside the segments the divide sees 0 / 1
   always_comb begin
      if (raw < p0) begin
         diff_in  = '0;
         fdiv_in  = RAW_W'(1);
         fbase_in = '0;
      end else if (raw < p1) begin
         diff_in  = raw - p0;
         fdiv_in  = p1 - p0;
         fbase_in = '0;
      end else if (raw < p2) begin
         diff_in  = raw - p1;
         fdiv_in  = p2 - p1;
         fbase_in = MID_WGT;
      end else begin
         diff_in  = '0;
         fdiv_in  = RAW_W'(1);
         fbase_in = TOP_WGT;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff  <= diff_in;
         fdiv_ff  <= fdiv_in;
         fbase_ff <= fbase_in;
      end
   end

   assign prod_in = {{QUO_W{1'b0}}, diff_ff} * {{RAW_W{1'b0}}, MID_Q};

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rem_ff[0]  <= prod_in;
         div_ff[0]  <= fdiv_ff;
         base_ff[0] <= fbase_ff;
         quo_ff[0]  <= '0;
      end
   end

   // restoring divide, msb of the quotient first
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      localparam int BIT = DIV_STAGES - 1 - k;
      logic [PROD_W-1:0] trial;
      logic              fit;
      logic [PROD_W-1:0] rem_in;
      logic [QUO_W-1:0]  quo_in;

      always_comb begin
         trial  = {{QUO_W{1'b0}}, div_ff[k]} << BIT;
         fit    = rem_ff[k] >= trial;
         rem_in = rem_ff[k];
         quo_in = quo_ff[k];
         if (fit) begin
            rem_in      = rem_ff[k] - trial;
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k+2]) begin
            base_ff[k+1] <= base_ff[k];
            quo_ff[k+1]  <= quo_in;
         end
      end

      if (k < DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[k+2]) begin
               rem_ff[k+1] <= rem_in;
               div_ff[k+1] <= div_ff[k];
            end
         end
      end
   end

   assign wgt = base_ff[DIV_STAGES] + {1'b0, quo_ff[DIV_STAGES]};

endmodule

@@ design/lcpc_merge.sv @@
module lcpc_merge import lcpc_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic [WGT_W-1:0] wgt [NUM_LANES],
   output rsp_data_type     data
);

   rsp_data_type data_ff, data_in;

   // saturate each lane and pack the result word
   always_comb begin
      data_in.kg_top_right    = sat_kg(wgt[LANE_TOP_RIGHT]);
      data_in.kg_bottom_right = sat_kg(wgt[LANE_BOTTOM_RIGHT]);
      data_in.kg_top_left     = sat_kg(wgt[LANE_TOP_LEFT]);
      data_in.kg_bottom_left  = sat_kg(wgt[LANE_BOTTOM_LEFT]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

@@ design/load_cell_piecewise_calibrate.sv @@
// four-corner load-cell calibration: each req word carries four 16-bit raw
// readings and gives one rsp word of four weights in kilograms with FRAC_BITS
// fraction bits (8 by default, so 34 kg reads as 8704). each corner has its own
// 48-bit calibration register holding the raw counts for 0, 17 and 34 kg; below
// the 0 kg point the weight is 0, at or above the 34 kg point it is 34 kg, and
// in between it is interpolated with the quotient truncated. one word is taken
// every cycle while req_stall is low; a word passes through a segment-select
// stage, a constant multiply stage, one restoring divider stage per quotient
// bit (FRAC_BITS + 5 of them) and the output register. the depth is set by
// that divider pipeline. stalls ripple back stage by stage, so empty stages
// still fill while a finished word waits. calibration writes take effect at
// once and should only be made while the pipe is empty.
module load_cell_piecewise_calibrate import lcpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_data_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   // calibration registers, one per corner
   logic [CAL_W-1:0] cal_ff [NUM_LANES];

   // pipeline occupancy and per-stage advance
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic [PIPE_DEPTH:0]   ready;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_load;

   logic [RAW_W-1:0] raw [NUM_LANES];
   logic [WGT_W-1:0] wgt [NUM_LANES];

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CAL_TOP_RIGHT:    cal_ff[LANE_TOP_RIGHT]    <= csr_wr_data;
            CSR_CAL_BOTTOM_RIGHT: cal_ff[LANE_BOTTOM_RIGHT] <= csr_wr_data;
            CSR_CAL_TOP_LEFT:     cal_ff[LANE_TOP_LEFT]     <= csr_wr_data;
            CSR_CAL_BOTTOM_LEFT:  cal_ff[LANE_BOTTOM_LEFT]  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // a stage moves when it is empty or the stage after it moves
   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ready[PIPE_DEPTH] = out_load;
      for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in = valid_ff;
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = rsp_valid_ff;

   // unpack the req word into lanes
   assign raw[LANE_TOP_RIGHT]    = req_data.raw_top_right;
   assign raw[LANE_BOTTOM_RIGHT] = req_data.raw_bottom_right;
   assign raw[LANE_TOP_LEFT]     = req_data.raw_top_left;
   assign raw[LANE_BOTTOM_LEFT]  = req_data.raw_bottom_left;

   // one interpolation lane per corner, all on the same stage enables
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      lcpc_lane u_lane (
         .clock    (clock),
         .stage_en (ready[PIPE_DEPTH-1:0]),
         .raw      (raw[i]),
         .cal      (cal_ff[i]),
         .wgt      (wgt[i])
      );
   end

   // saturate and register the rsp word
   lcpc_merge u_merge (
      .clock (clock),
      .load  (out_load),
      .wgt   (wgt),
      .data  (rsp_data)
   );

endmodule

@@ design/lcpc_checker.sv @@
module lcpc_checker import lcpc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_data_type         rsp_data
);

   // a stalled rsp word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed under stall");

   // no weight goes past the 34 kg ceiling
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.kg_top_right) <= KG_CEIL
                 && 32'(rsp_data.kg_bottom_right) <= KG_CEIL
                 && 32'(rsp_data.kg_top_left) <= KG_CEIL
                 && 32'(rsp_data.kg_bottom_left) <= KG_CEIL)
      else $error("weight above full scale");

   // reset empties the pipe
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

   // a free output with nothing pending never pushes back on req
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid) |-> !req_stall)
      else $error("req stalled with an empty output");

endmodule

bind load_cell_piecewise_calibrate lcpc_checker u_lcpc_checker (.*);
